// ===== hw/rtl/ip_locality_classifier_unit_assert.svh =====
// Assertion macros used by the checker file of the locality classifier.
`ifndef IP_LOCALITY_CLASSIFIER_UNIT_ASSERT_SVH
`define IP_LOCALITY_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ILC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ILC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ilc_pkg.sv =====
// Types, constants and helper functions of the locality classifier.
package ilc_pkg;

  localparam int unsigned ENTRIES_DEF = 256;

  localparam logic [31:0] LOOP_HOST  = 32'h7f00_0001;
  localparam logic [31:0] MASK_8     = 32'hff00_0000;
  localparam logic [31:0] NET_LOOP   = 32'h7f00_0000;
  localparam logic [31:0] NET_10     = 32'h0a00_0000;
  localparam logic [31:0] MASK_12    = 32'hfff0_0000;
  localparam logic [31:0] NET_172    = 32'hac10_0000;
  localparam logic [31:0] NEAR_MASK  = 32'hffff_0000;
  localparam logic [31:0] NET_192    = 32'hc0a8_0000;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND   = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIST_OURSELVES = 2'd0,
    DIST_LAN       = 2'd1,
    DIST_NEARBY    = 2'd2,
    DIST_FAR       = 2'd3
  } dist_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] mask;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

  typedef struct packed {
    logic exact;
    logic lan;
    logic near;
  } match_t;

  function automatic logic is_loopback(input logic [31:0] a);
    return (a == LOOP_HOST) || ((a & MASK_8) == NET_LOOP);
  endfunction

  function automatic logic is_private(input logic [31:0] a);
    return ((a & MASK_8) == NET_10) || ((a & MASK_12) == NET_172) ||
           ((a & NEAR_MASK) == NET_192);
  endfunction

endpackage

// ===== hw/rtl/ilc_if.sv =====
// Request and response channel interfaces of the locality classifier.
interface ilc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] address;
  logic [31:0] netmask;

  modport source (output valid, output op, output address, output netmask, input ready);
  modport sink (input valid, input op, input address, input netmask, output ready);
endinterface

interface ilc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] distance;
  logic       internal;
  logic       append_dropped;

  modport source (output valid, output distance, output internal, output append_dropped,
                  input ready);
  modport sink (input valid, input distance, input internal, input append_dropped,
                output ready);
endinterface

// ===== hw/rtl/ip_locality_classifier_unit.sv =====
// Top level of the locality classifier: sequencer, table and compare unit.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    op, address, netmask
//   rsp      out  valid / ready    distance, internal, append_dropped
//
// Clear, append and unused ops go straight from ST_IDLE to ST_DONE; a classify
// passes through ST_SCAN (skipped for an empty table) and ST_DRAIN: the single table read port
// delivers one entry per cycle to the compare unit.
// req.ready is high only while the sequencer is idle; the response sits in an
// output register, so a new request is taken while rsp is stalled.
// Reset (rst, synchronous) empties the table count; entry contents are kept.
module ip_locality_classifier_unit #(
  parameter int unsigned ENTRIES = ilc_pkg::ENTRIES_DEF
) (
  input logic     clk,
  input logic     rst,
  ilc_req_if.sink   req,
  ilc_rsp_if.source rsp
);
  import ilc_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  op_t              op_q;
  logic [31:0]      addr_q;
  logic             dropped_q;
  logic             rd_vld;
  logic             accept;
  logic             last_issue;
  logic             load;
  logic             table_full;
  logic             we;
  entry_t           wdata;
  entry_t           rdata;
  scan_ctl_t        scan_ctl;
  match_t           hits;
  dist_t            dist_res;
  logic             int_res;
  logic             loop_hit;

  assign accept     = req.valid && req.ready;
  assign table_full = (count >= CNT_W'(ENTRIES));
  assign last_issue = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign load       = (state == ST_DONE) && (!rsp.valid || rsp.ready);
  assign we         = accept && (op_t'(req.op) == OP_APPEND) && !table_full;
  assign wdata.addr = req.address;
  assign wdata.mask = req.netmask;

  assign scan_ctl.clear = accept;
  assign scan_ctl.valid = rd_vld;

  ilc_table #(.ENTRIES(ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  ilc_match u_match (
    .clk   (clk),
    .rst   (rst),
    .ctl   (scan_ctl),
    .ent   (rdata),
    .query (addr_q),
    .hits  (hits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (op_t'(req.op) == OP_CLASSIFY) begin
            state_next = (count == '0) ? ST_DRAIN : ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      if (accept) begin
        idx <= '0;
        if (op_t'(req.op) == OP_CLEAR) begin
          count <= '0;
        end else if (we) begin
          count <= count + CNT_W'(1);
        end
      end else if (state == ST_SCAN) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_t'(req.op);
      addr_q    <= req.address;
      dropped_q <= (op_t'(req.op) == OP_APPEND) && table_full;
    end
  end

  always_comb begin
    loop_hit = is_loopback(addr_q);
    if (loop_hit || hits.exact) begin
      dist_res = DIST_OURSELVES;
    end else if (hits.lan) begin
      dist_res = DIST_LAN;
    end else if (hits.near) begin
      dist_res = DIST_NEARBY;
    end else begin
      dist_res = DIST_FAR;
    end
    int_res = loop_hit || is_private(addr_q) || hits.lan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (op_q == OP_CLASSIFY) begin
        rsp.distance <= dist_res;
        rsp.internal <= int_res;
      end else begin
        rsp.distance <= DIST_OURSELVES;
        rsp.internal <= 1'b0;
      end
      rsp.append_dropped <= dropped_q;
    end
  end

endmodule

// ===== hw/rtl/ilc_table.sv =====
// Entry table: one write port and one registered read port.
module ilc_table #(
  parameter int unsigned ENTRIES = ilc_pkg::ENTRIES_DEF
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr,
  input  ilc_pkg::entry_t                           wdata,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr,
  output ilc_pkg::entry_t                           rdata
);
  import ilc_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ilc_match.sv =====
// Shared compare unit: checks one entry per cycle and accumulates the hit flags.
module ilc_match (
  input  logic               clk,
  input  logic               rst,
  input  ilc_pkg::scan_ctl_t ctl,
  input  ilc_pkg::entry_t    ent,
  input  logic [31:0]        query,
  output ilc_pkg::match_t    hits
);
  import ilc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hits <= '0;
    end else if (ctl.valid) begin
      hits.exact <= hits.exact | (ent.addr == query);
      // Masked equality: no bit under the mask differs.
      hits.lan   <= hits.lan | (((query ^ ent.addr) & ent.mask) == 32'd0);
      hits.near  <= hits.near | ((query & NEAR_MASK) == (ent.addr & NEAR_MASK));
    end
  end

endmodule

// ===== hw/rtl/ilc_checker.sv =====
// Port-level checker for the locality classifier and its bind statement.
`include "ip_locality_classifier_unit_assert.svh"

module ilc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] distance,
  input logic       internal,
  input logic       append_dropped
);
  import ilc_pkg::*;

  `ILC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({distance, internal, append_dropped}), "stalled response changed")
  `ILC_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
  `ILC_ASSERT_NOW(a_lan_internal, rsp_valid && (distance == DIST_LAN), internal, "LAN result not internal")
  `ILC_ASSERT_NOW(a_drop_clean, rsp_valid && append_dropped, (distance == DIST_OURSELVES) && !internal, "dropped append carries class bits")

endmodule

bind ip_locality_classifier_unit ilc_checker u_ilc_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .distance       (rsp.distance),
  .internal       (rsp.internal),
  .append_dropped (rsp.append_dropped)
);
